@@ src/olspm_pkg.sv @@
`default_nettype none
package olspm_pkg;
    localparam int SineDepthDefault = 256;
    localparam int PhaseBitsDefault = 16;
    localparam logic [15:0] FallbackBus = 16'd5120;
    localparam logic [15:0] HalfDuty = 16'd32768;

    localparam logic [2:0] RegAmplitude = 3'd0;
    localparam logic [2:0] RegPhaseStep = 3'd1;
    localparam logic [2:0] RegClampLo = 3'd2;
    localparam logic [2:0] RegClampHi = 3'd3;
    localparam logic [2:0] RegCurrentLimit = 3'd4;
    localparam logic [2:0] RegFilterAlpha = 3'd5;

    localparam logic [1:0] ModeIdle = 2'd0;
    localparam logic [1:0] ModePower = 2'd1;
    localparam logic [1:0] ModeError = 2'd2;

    typedef struct packed {
        logic [15:0] leg1_current;
        logic        leg1_valid;
        logic [15:0] leg2_current;
        logic        leg2_valid;
        logic [14:0] bus_voltage;
        logic        bus_valid;
        logic        run_request;
    } t_in_word;

    typedef struct packed {
        logic [15:0] duty_leg1;
        logic [15:0] duty_leg2;
        logic        outputs_enabled;
        logic [1:0]  mode_now;
        logic [15:0] reference_voltage;
    } t_out_word;

    typedef struct packed {
        logic load;     // capture the input word, hold samples, step filter/phase
        logic mult;     // compute the signed sine reference and record its sign
        logic mode;     // update mode, prepare divide
        logic div_step; // one quotient bit
        logic finish;   // apply duties, form result
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_status;

    // quarter-wave sine entry, Q1.15
    function automatic logic [15:0] sine_entry(input logic [31:0] i, input int depth);
        logic [63:0] z, z2, t, s;
        z = (64'(i) * 64'd65536) / 64'(depth);
        z2 = (z * z) >> 16;
        t = 64'd42048 - ((z2 * 64'd4640) >> 16);
        t = 64'd102944 - ((z2 * t) >> 16);
        s = (z * t) >> 16;
        s = (s + 64'd1) >> 1;
        if (s > 64'd32767) s = 64'd32767;
        return s[15:0];
    endfunction
endpackage
`default_nettype wire

@@ src/olspm_if.sv @@
`default_nettype none
interface olspm_in_if;
    logic valid;
    logic ready;
    olspm_pkg::t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface olspm_out_if;
    logic valid;
    logic ready;
    olspm_pkg::t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface olspm_cfg_if;
    logic valid;
    logic ready;
    logic [2:0] index;
    logic [15:0] value;
    modport source (output valid, output index, output value, input ready);
    modport sink (input valid, input index, input value, output ready);
endinterface
`default_nettype wire

@@ src/open_loop_sine_pwm_modulator.sv @@
`default_nettype none
// channel  dir  word
// in       in   leg currents, bus voltage, valid flags, run request
// out      out  duties, enable, mode, reference
// cfg      in   register index 0..5, 16-bit value
// An item passes through load, reference multiply, mode, a 28-step
// serial duty divider and finish; the result is then held until taken.
// Synchronous active-low reset restores register defaults and idle mode.
// A stalled result holds the block; no new word is taken until it leaves.
module open_loop_sine_pwm_modulator #(
    parameter int SINE_TABLE_DEPTH = olspm_pkg::SineDepthDefault,
    parameter int PHASE_BITS = olspm_pkg::PhaseBitsDefault
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    olspm_in_if.sink in_ch,
    olspm_out_if.source out_ch,
    olspm_cfg_if.sink cfg_ch
);
    import olspm_pkg::*;

    t_cmd cmd;
    t_status status;

    assign cfg_ch.ready = 1'b1;

    olspm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .o_in_ready(in_ch.ready),
        .o_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .i_status(status), .o_cmd(cmd)
    );

    olspm_datapath #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH), .PHASE_BITS(PHASE_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.data),
        .i_cfg_we(cfg_ch.valid), .i_cfg_index(cfg_ch.index), .i_cfg_value(cfg_ch.value),
        .i_cmd(cmd), .o_status(status), .o_out(out_ch.data)
    );

    a_onecmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.mult, cmd.mode, cmd.div_step, cmd.finish}))
        else $error("several commands at once");
    a_noaccept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> !in_ch.ready)
        else $error("input taken while result pending");
    a_enmode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> (out_ch.data.outputs_enabled == (out_ch.data.mode_now == ModePower)))
        else $error("enable disagrees with mode");
endmodule
`default_nettype wire

@@ src/olspm_ctrl.sv @@
`default_nettype none
module olspm_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    input  wire olspm_pkg::t_status i_status,
    output olspm_pkg::t_cmd       o_cmd
);
    import olspm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_MULT, S_MODE, S_DIV, S_FIN, S_OUT
    } t_state;

    t_state r_state;

    always_comb begin
        o_cmd = '0;
        o_in_ready = (r_state == S_IDLE);
        o_cmd.load = (r_state == S_IDLE) && i_in_valid;
        o_cmd.mult = (r_state == S_MULT);
        o_cmd.mode = (r_state == S_MODE);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.finish = (r_state == S_FIN);
        o_out_valid = (r_state == S_OUT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: if (i_in_valid) r_state <= S_MULT;
                S_MULT: r_state <= S_MODE;
                S_MODE: r_state <= S_DIV;
                S_DIV: if (i_status.div_done) r_state <= S_FIN;
                S_FIN: r_state <= S_OUT;
                S_OUT: if (i_out_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ src/olspm_datapath.sv @@
`default_nettype none
module olspm_datapath #(
    parameter int SINE_TABLE_DEPTH = olspm_pkg::SineDepthDefault,
    parameter int PHASE_BITS = olspm_pkg::PhaseBitsDefault
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire olspm_pkg::t_in_word i_in,
    input  wire logic                i_cfg_we,
    input  wire logic [2:0]          i_cfg_index,
    input  wire logic [15:0]         i_cfg_value,
    input  wire olspm_pkg::t_cmd     i_cmd,
    output olspm_pkg::t_status       o_status,
    output olspm_pkg::t_out_word     o_out
);
    import olspm_pkg::*;

    localparam int IdxBits = $clog2(SINE_TABLE_DEPTH);
    localparam int FracBits = PHASE_BITS - 2;
    localparam int QBits = 28; // dividend |ref| * 2^15 + vb/2 stays below 2^28

    logic [12:0] r_amplitude;
    logic [14:0] r_phase_step;
    logic [15:0] r_clamp_lo, r_clamp_hi;
    logic [14:0] r_current_limit;
    logic [15:0] r_filter_alpha;

    logic [PHASE_BITS-1:0] r_phase;
    logic [1:0] r_mode;
    logic [31:0] r_filt;
    logic signed [15:0] r_cur1, r_cur2;
    logic [14:0] r_bus;
    logic [15:0] r_last1, r_last2;

    logic r_run;
    logic signed [16:0] r_sine;
    logic [15:0] r_ref;
    logic [31:0] r_rem;     // running remainder
    logic [QBits-1:0] r_num;
    logic [QBits-1:0] r_quot;
    logic [15:0] r_vb;
    logic [4:0] r_cnt;
    logic r_neg;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amplitude <= 13'd5120;
            r_phase_step <= 15'd328;
            r_clamp_lo <= 16'd6554;
            r_clamp_hi <= 16'd58982;
            r_current_limit <= 15'd2048;
            r_filter_alpha <= 16'd66;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                RegAmplitude: r_amplitude <= i_cfg_value[12:0];
                RegPhaseStep: r_phase_step <= i_cfg_value[14:0];
                RegClampLo: r_clamp_lo <= i_cfg_value;
                RegClampHi: r_clamp_hi <= i_cfg_value;
                RegCurrentLimit: r_current_limit <= i_cfg_value[14:0];
                RegFilterAlpha: r_filter_alpha <= i_cfg_value;
                default: ;
            endcase
        end
    end

    // hold samples
    logic signed [15:0] n_cur1, n_cur2;
    logic [14:0] n_bus;
    assign n_cur1 = i_in.leg1_valid ? i_in.leg1_current : r_cur1;
    assign n_cur2 = i_in.leg2_valid ? i_in.leg2_current : r_cur2;
    assign n_bus = i_in.bus_valid ? i_in.bus_voltage : r_bus;

    // filter: 32x16 multiply
    logic signed [32:0] diff;
    logic [31:0] mag;
    logic [47:0] prod;
    logic [31:0] stp;
    logic [31:0] n_filt;
    assign diff = $signed({2'b0, n_bus, 16'b0}) - $signed({1'b0, r_filt});
    assign mag = diff[32] ? 32'(-diff) : diff[31:0];
    assign prod = 48'(mag) * 48'(r_filter_alpha) + 48'd32768;
    assign stp = prod[47:16];
    assign n_filt = diff[32] ? r_filt - stp : r_filt + stp;

    // constant quarter-wave table
    logic [15:0] sine_rom [SINE_TABLE_DEPTH];
    for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_rom
        assign sine_rom[g] = sine_entry(32'(g), SINE_TABLE_DEPTH);
    end

    // phase and sine lookup
    logic [PHASE_BITS-1:0] n_phase;
    logic [1:0] quad;
    logic [FracBits-1:0] frac;
    logic [IdxBits-1:0] idx;
    logic [IdxBits-1:0] mir;
    logic [15:0] tab_val;
    logic [15:0] sv;
    logic [FracBits+IdxBits-1:0] fscaled;
    assign n_phase = r_phase + PHASE_BITS'(r_phase_step);
    assign quad = n_phase[PHASE_BITS-1 -: 2];
    assign frac = n_phase[FracBits-1:0];
    assign fscaled = (FracBits+IdxBits)'(frac) * (FracBits+IdxBits)'(SINE_TABLE_DEPTH);
    assign idx = fscaled[FracBits +: IdxBits];
    assign mir = IdxBits'(SINE_TABLE_DEPTH) - idx;
    always_comb begin
        tab_val = sine_rom[quad[0] ? mir : idx];
        if (quad[0] && idx == '0) sv = 16'd32767;
        else sv = tab_val;
    end

    // reference from the sine magnitude
    logic [15:0] smag;
    logic [28:0] rprod;
    logic [13:0] rm;
    assign smag = r_sine[16] ? 16'(-r_sine) : r_sine[15:0];
    assign rprod = 29'(r_amplitude) * 29'(smag) + 29'd16384;
    assign rm = rprod[28:15];

    // mode
    logic over;
    logic [1:0] n_mode;
    always_comb begin
        over = (r_cur1 > $signed({1'b0, r_current_limit}))
            || (r_cur1 < -$signed({1'b0, r_current_limit}))
            || (r_cur2 > $signed({1'b0, r_current_limit}))
            || (r_cur2 < -$signed({1'b0, r_current_limit}));
        n_mode = r_mode;
        if (!r_run) n_mode = ModeIdle;
        else if (r_mode == ModeIdle) n_mode = ModePower;
        if (over) n_mode = ModeError;
    end

    // bus voltage for the duty, falls back to FallbackBus when the filtered bus is at or below 256
    logic [15:0] vb_next;
    assign vb_next = (r_filt > 32'h0100_0000) ? r_filt[31:16] : FallbackBus;

    // divider: restoring, one bit per cycle
    logic [31:0] trial;
    assign trial = {r_rem[30:0], r_num[QBits-1]};
    assign o_status.div_done = (r_cnt == 5'(QBits - 1));

    // duty and clamp
    logic signed [29:0] d1, d2;
    logic [15:0] c1, c2;
    function automatic logic [15:0] clampd(input logic signed [29:0] v,
                                           input logic [15:0] lo, input logic [15:0] hi);
        if (v > $signed({14'b0, hi})) return hi;
        if (v < $signed({14'b0, lo})) return lo;
        return v[15:0];
    endfunction
    assign d1 = 30'sd32768 + (r_neg ? -$signed({2'b0, r_quot}) : $signed({2'b0, r_quot}));
    assign d2 = 30'sd65536 - d1;
    assign c1 = clampd(d1, r_clamp_lo, r_clamp_hi);
    assign c2 = clampd(d2, r_clamp_lo, r_clamp_hi);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_mode <= ModeIdle;
            r_filt <= '0;
            r_cur1 <= '0;
            r_cur2 <= '0;
            r_bus <= '0;
            r_last1 <= HalfDuty;
            r_last2 <= HalfDuty;
            r_cnt <= '0;
        end else begin
            if (i_cmd.load) begin
                r_cur1 <= n_cur1;
                r_cur2 <= n_cur2;
                r_bus <= n_bus;
                r_filt <= n_filt;
                r_phase <= n_phase;
                r_run <= i_in.run_request;
                r_sine <= quad[1] ? -$signed({1'b0, sv}) : $signed({1'b0, sv});
            end
            if (i_cmd.mult) begin
                r_neg <= r_sine[16];
                r_ref <= r_sine[16] ? 16'(-$signed({2'b0, rm})) : {2'b0, rm};
            end
            if (i_cmd.mode) begin
                r_mode <= n_mode;
                r_vb <= vb_next;
                // fold vb/2 into the dividend for round-half-up
                r_num <= QBits'({rm, 15'b0}) + QBits'(vb_next[15:1]);
                r_rem <= '0;
                r_cnt <= '0;
                r_quot <= '0;
            end
            if (i_cmd.div_step) begin
                if (trial >= {16'b0, r_vb}) begin
                    r_rem <= trial - {16'b0, r_vb};
                    r_quot <= {r_quot[QBits-2:0], 1'b1};
                end else begin
                    r_rem <= trial;
                    r_quot <= {r_quot[QBits-2:0], 1'b0};
                end
                r_num <= {r_num[QBits-2:0], 1'b0};
                r_cnt <= r_cnt + 5'd1;
            end
            if (i_cmd.finish && r_mode == ModePower) begin
                r_last1 <= c1;
                r_last2 <= c2;
            end
        end
    end

    assign o_out.duty_leg1 = r_last1;
    assign o_out.duty_leg2 = r_last2;
    assign o_out.outputs_enabled = (r_mode == ModePower);
    assign o_out.mode_now = r_mode;
    assign o_out.reference_voltage = r_ref;
endmodule
`default_nettype wire
